// ===== hw/rtl/mts_pkg.sv =====
// Shared types and constants for the markup tag stripper.
// Beat payload structs, tag characters and the scan result type.
// No dependencies.
package mts_pkg;

    localparam int WINDOW_DEPTH = 12;
    localparam int FILL_BITS    = 4;
    localparam int COUNT_BITS   = 16;
    localparam int PADDR_BITS   = 3;

    localparam logic [7:0] CH_OPEN  = 8'h7B;
    localparam logic [7:0] CH_CLOSE = 8'h7D;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam logic [FILL_BITS-1:0] TAG_LEN_NONE  = 4'd0;
    localparam logic [FILL_BITS-1:0] TAG_LEN_SLASH = 4'd4;
    localparam logic [FILL_BITS-1:0] TAG_LEN_ICON  = 4'd6;
    localparam logic [FILL_BITS-1:0] TAG_LEN_LONG  = 4'd12;

    typedef logic [WINDOW_DEPTH-1:0][7:0] t_win;

    typedef enum logic [1:0] {
        SCAN_PREFIX,
        SCAN_VALID,
        SCAN_FAIL
    } t_scan;

    typedef struct packed {
        t_scan                kind;
        logic [FILL_BITS-1:0] len;
    } t_scan_res;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_end;
    } t_in_beat;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        has_byte;
        logic        message_done;
        logic [15:0] kept_count;
    } t_out_beat;

endpackage

// ===== hw/rtl/mts_tag_check.sv =====
// Tag compare unit: checks one window byte against the tag grammar.
// Depends on mts_pkg for characters, tag lengths and the scan result type.
module mts_tag_check (
    input  logic [mts_pkg::FILL_BITS-1:0] i_pos,
    input  logic [7:0]                    i_c1,
    input  logic [7:0]                    i_byte,
    output mts_pkg::t_scan_res            o_res
);

    logic [mts_pkg::FILL_BITS-1:0] len;
    logic                          ok;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

    always_comb begin
        if (i_c1 == mts_pkg::CH_B || i_c1 == mts_pkg::CH_F) begin
            len = mts_pkg::TAG_LEN_LONG;
        end else if (i_c1 == mts_pkg::CH_SLASH) begin
            len = mts_pkg::TAG_LEN_SLASH;
        end else if (i_c1 == mts_pkg::CH_I) begin
            len = mts_pkg::TAG_LEN_ICON;
        end else begin
            len = mts_pkg::TAG_LEN_NONE;
        end

        if (i_pos == len - 4'd1) begin
            ok = (i_byte == mts_pkg::CH_CLOSE);
        end else if (i_pos == 4'd2) begin
            if (len == mts_pkg::TAG_LEN_SLASH) begin
                ok = (i_byte == mts_pkg::CH_B) || (i_byte == mts_pkg::CH_F);
            end else begin
                ok = (i_byte == mts_pkg::CH_EQ);
            end
        end else if (len == mts_pkg::TAG_LEN_ICON) begin
            ok = is_hex(i_byte);
        end else begin
            ok = 1'b1;
        end

        o_res.len = len;
        if (i_pos == 4'd1) begin
            o_res.kind = (len != mts_pkg::TAG_LEN_NONE) ? mts_pkg::SCAN_PREFIX
                                                        : mts_pkg::SCAN_FAIL;
        end else if (!ok) begin
            o_res.kind = mts_pkg::SCAN_FAIL;
        end else if (i_pos == len - 4'd1) begin
            o_res.kind = mts_pkg::SCAN_VALID;
        end else begin
            o_res.kind = mts_pkg::SCAN_PREFIX;
        end
    end

endmodule

// ===== hw/rtl/markup_tag_stripper_unit.sv =====
// Markup tag stripper top level: window sequencer, output stages, APB register.
// Depends on mts_pkg and mts_tag_check.
//
// Usage:
//   Input channel (i_in_valid, i_in_data, o_in_stall) takes one message byte
//   per beat, in_end set on the last byte. Output channel (o_out_valid,
//   o_out_data, i_out_stall) returns kept bytes with a running kept count;
//   the last beat of a message carries message_done, a bare end marker
//   (has_byte clear) when the final input byte produced nothing.
//   One byte enters at a time: the input is stalled from acceptance until
//   the byte and any held window bytes it releases have been processed.
//   A plain text byte passes through accept, scan, empty check and flush, and
//   its result is in the output register once the flush is done. A failed
//   tag replays the held window byte by byte through the single tag
//   compare unit, so a byte that ends a message on a long unfinished tag
//   keeps the input stalled while the whole held window is scanned again.
//   While the receiver stalls, the output register and one hold stage keep
//   results; the scan waits whenever it has a result and both are full.
//   Register 0 (address 0, bit 0) is drop_high_bytes, reset 1; write it only
//   while the block is idle. Reset empties the window and clears the count.
module markup_tag_stripper_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  mts_pkg::t_in_beat              i_in_data,
    output logic                           o_in_stall,
    output logic                           o_out_valid,
    output mts_pkg::t_out_beat             o_out_data,
    input  logic                           i_out_stall,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mts_pkg::PADDR_BITS-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH
    } t_state;

    localparam logic REG_DROP_HIGH = 1'b0;
    localparam logic [mts_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;

    t_state                          r_state, n_state;
    mts_pkg::t_win                   r_buf, n_buf;
    logic [mts_pkg::FILL_BITS-1:0]   r_fill, n_fill;
    logic [mts_pkg::FILL_BITS-1:0]   r_tot, n_tot;
    logic                            r_last, n_last;
    logic [mts_pkg::COUNT_BITS-1:0]  r_kept, n_kept;
    logic                            r_hold_v, n_hold_v;
    mts_pkg::t_out_beat              r_hold, n_hold;
    logic                            r_out_v, n_out_v;
    mts_pkg::t_out_beat              r_out, n_out;
    logic                            r_drop_high, n_drop_high;

    logic [7:0]                      cur_byte;
    logic [7:0]                      c1;
    mts_pkg::t_scan_res              scan;
    logic                            keep_ok;
    logic                            out_free;
    logic                            can_emit;
    logic                            emit;
    logic [7:0]                      emit_byte;
    logic [mts_pkg::COUNT_BITS-1:0]  kept_inc;
    logic                            reg_wr;

    function automatic mts_pkg::t_win shift_win(input mts_pkg::t_win w,
                                                input logic [mts_pkg::FILL_BITS-1:0] amt);
        mts_pkg::t_win r;
        r = w;
        unique case (amt)
            mts_pkg::TAG_LEN_SLASH: begin
                for (int j = 0; j < mts_pkg::WINDOW_DEPTH - 4; j++) r[j] = w[j + 4];
            end
            mts_pkg::TAG_LEN_ICON: begin
                for (int j = 0; j < mts_pkg::WINDOW_DEPTH - 6; j++) r[j] = w[j + 6];
            end
            mts_pkg::TAG_LEN_LONG: begin
                r = w;
            end
            default: begin
                for (int j = 0; j < mts_pkg::WINDOW_DEPTH - 1; j++) r[j] = w[j + 1];
            end
        endcase
        return r;
    endfunction

    assign cur_byte = r_buf[r_fill];
    assign c1       = (r_fill == 4'd1) ? cur_byte : r_buf[1];
    assign keep_ok  = !((cur_byte < mts_pkg::CH_SPACE) && (cur_byte != mts_pkg::CH_LF)) &&
                      !(cur_byte[7] && r_drop_high);
    assign out_free = !r_out_v || !i_out_stall;
    assign can_emit = !r_hold_v || out_free;
    assign kept_inc = (r_kept == COUNT_MAX) ? r_kept : r_kept + 1'b1;

    mts_tag_check u_check (
        .i_pos  (r_fill),
        .i_c1   (c1),
        .i_byte (cur_byte),
        .o_res  (scan)
    );

    assign reg_wr = psel && penable && pwrite && pready &&
                    (paddr[mts_pkg::PADDR_BITS-1] == REG_DROP_HIGH);

    always_comb begin
        n_state     = r_state;
        n_buf       = r_buf;
        n_fill      = r_fill;
        n_tot       = r_tot;
        n_last      = r_last;
        n_kept      = r_kept;
        n_hold_v    = r_hold_v;
        n_hold      = r_hold;
        n_out_v     = r_out_v && i_out_stall;
        n_out       = r_out;
        n_drop_high = reg_wr ? pwdata[0] : r_drop_high;
        emit        = 1'b0;
        emit_byte   = cur_byte;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_buf[r_tot] = i_in_data.in_byte;
                    n_tot        = r_tot + 4'd1;
                    n_last       = i_in_data.in_end;
                    n_state      = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_tot != r_fill) begin
                    if (r_fill == 4'd0) begin
                        if (cur_byte == mts_pkg::CH_OPEN) begin
                            n_fill = 4'd1;
                        end else if (!keep_ok) begin
                            n_buf = shift_win(r_buf, 4'd1);
                            n_tot = r_tot - 4'd1;
                        end else if (can_emit) begin
                            emit  = 1'b1;
                            n_buf = shift_win(r_buf, 4'd1);
                            n_tot = r_tot - 4'd1;
                        end
                    end else begin
                        unique case (scan.kind)
                            mts_pkg::SCAN_PREFIX: begin
                                n_fill = r_fill + 4'd1;
                            end
                            mts_pkg::SCAN_VALID: begin
                                n_buf  = shift_win(r_buf, scan.len);
                                n_tot  = r_tot - scan.len;
                                n_fill = 4'd0;
                            end
                            mts_pkg::SCAN_FAIL: begin
                                if (can_emit) begin
                                    emit      = 1'b1;
                                    emit_byte = mts_pkg::CH_OPEN;
                                    n_buf     = shift_win(r_buf, 4'd1);
                                    n_tot     = r_tot - 4'd1;
                                    n_fill    = 4'd0;
                                end
                            end
                            default: begin
                                n_fill = r_fill;
                            end
                        endcase
                    end
                end else if (r_last && r_fill != 4'd0) begin
                    if (can_emit) begin
                        emit      = 1'b1;
                        emit_byte = mts_pkg::CH_OPEN;
                        n_buf     = shift_win(r_buf, 4'd1);
                        n_tot     = r_tot - 4'd1;
                        n_fill    = 4'd0;
                    end
                end else begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (r_hold_v) begin
                    if (out_free) begin
                        n_out_v              = 1'b1;
                        n_out                = r_hold;
                        n_out.message_done   = r_last;
                        n_hold_v             = 1'b0;
                        n_state              = ST_IDLE;
                        if (r_last) begin
                            n_kept = '0;
                        end
                    end
                end else if (r_last) begin
                    if (out_free) begin
                        n_out_v            = 1'b1;
                        n_out.out_byte     = 8'h00;
                        n_out.has_byte     = 1'b0;
                        n_out.message_done = 1'b1;
                        n_out.kept_count   = 16'(r_kept);
                        n_kept             = '0;
                        n_state            = ST_IDLE;
                    end
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (emit) begin
            n_kept = kept_inc;
            if (r_hold_v) begin
                n_out_v = 1'b1;
                n_out   = r_hold;
            end
            n_hold_v            = 1'b1;
            n_hold.out_byte     = emit_byte;
            n_hold.has_byte     = 1'b1;
            n_hold.message_done = 1'b0;
            n_hold.kept_count   = 16'(kept_inc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_tot       <= '0;
            r_last      <= 1'b0;
            r_kept      <= '0;
            r_hold_v    <= 1'b0;
            r_out_v     <= 1'b0;
            r_drop_high <= 1'b1;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_tot       <= n_tot;
            r_last      <= n_last;
            r_kept      <= n_kept;
            r_hold_v    <= n_hold_v;
            r_out_v     <= n_out_v;
            r_drop_high <= n_drop_high;
        end
        r_buf  <= n_buf;
        r_hold <= n_hold;
        r_out  <= n_out;
    end

    always_comb begin
        prdata = '0;
        if (paddr[mts_pkg::PADDR_BITS-1] == REG_DROP_HIGH) begin
            prdata[0] = r_drop_high;
        end
    end

    assign pready      = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

`ifndef NO_ASSERTIONS
    a_fill_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill <= r_tot) && (r_tot <= mts_pkg::FILL_BITS'(mts_pkg::WINDOW_DEPTH)))
        else $error("window fill exceeds held bytes or depth");

    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |->
        ((r_tot == r_fill) && (r_fill < mts_pkg::FILL_BITS'(mts_pkg::WINDOW_DEPTH))))
        else $error("idle with unscanned bytes or a full window");

    a_valid_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_tot != r_fill && r_fill != 4'd0 &&
         scan.kind == mts_pkg::SCAN_VALID) |-> (scan.len == r_fill + 4'd1))
        else $error("tag accepted at a length that does not match its kind");

    a_count_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH && r_last && n_state == ST_IDLE) |=> (r_kept == '0))
        else $error("kept count not cleared after message end");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && i_out_stall) |=> (r_out_v && $stable(r_out)))
        else $error("stalled output beat overwritten");
`endif

endmodule
